// ----- design/signed_fixed_point_alu_top_macros.svh -----
// ---------------------------------------------------------------------------
// signed_fixed_point_alu_top_macros
// assertion macros for the fixed-point alu top
// ---------------------------------------------------------------------------
`ifndef SIGNED_FIXED_POINT_ALU_TOP_MACROS_SVH
`define SIGNED_FIXED_POINT_ALU_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define SFPA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SFPA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/sfpa_pkg.sv -----
// ---------------------------------------------------------------------------
// sfpa_pkg
// commands and pipeline stage type of the signed fixed-point alu
// ---------------------------------------------------------------------------
`default_nettype none

package sfpa_pkg;

  typedef enum logic [3:0] {
    CMD_ADD     = 4'd0,
    CMD_SUB     = 4'd1,
    CMD_MUL     = 4'd2,
    CMD_DIV     = 4'd3,
    CMD_LT      = 4'd4,
    CMD_GT      = 4'd5,
    CMD_LE      = 4'd6,
    CMD_GE      = 4'd7,
    CMD_EQ      = 4'd8,
    CMD_NE      = 4'd9,
    CMD_MIN     = 4'd10,
    CMD_MAX     = 4'd11,
    CMD_INC     = 4'd12,
    CMD_DEC     = 4'd13,
    CMD_TOINT   = 4'd14,
    CMD_FROMINT = 4'd15
  } cmd_e;

  // payload carried along the pipeline
  typedef struct packed {
    cmd_e        cmd;
    logic        neg;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [31:0] rem;
    logic [31:0] quo;
    logic [31:0] simple_res;
    logic        cmp;
  } stage_t;

endpackage

`default_nettype wire

// ----- design/sfpa_if.sv -----
// ---------------------------------------------------------------------------
// sfpa_if
// valid/ready channels for operations and results
// ---------------------------------------------------------------------------
`default_nettype none

interface sfpa_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  command;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  modport source (output valid, command, operand_a, operand_b, input ready);
  modport sink   (input valid, command, operand_a, operand_b, output ready);
endinterface

interface sfpa_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] result_value;
  logic        compare_true;
  logic        divide_by_zero;
  modport source (output valid, result_value, compare_true, divide_by_zero, input ready);
  modport sink   (input valid, result_value, compare_true, divide_by_zero, output ready);
endinterface

`default_nettype wire

// ----- design/signed_fixed_point_alu_top.sv -----
// ---------------------------------------------------------------------------
// signed_fixed_point_alu_top
// pipelined signed 32-bit fixed-point alu with FRAC_BITS fraction bits
// ---------------------------------------------------------------------------
// usage:
//   in_i carries command, operand_a and operand_b; a transfer happens when
//   valid and ready are both high. out_o returns one result per operation,
//   in order, with result_value, compare_true and divide_by_zero.
// stages from the input transfer to out_o.valid: one entry stage,
//   32 + FRAC_BITS restoring divider stages with one quotient bit each,
//   one multiplier stage and the output register.
// throughput: one operation per cycle while out_o is not stalled; every
//   command walks the same pipe.
// reset: clears all valid bits, the pipe comes up empty and ready.
// stall: while out_o holds a result that is not taken, the whole pipe
//   freezes and in_i.ready drops; nothing is lost or repeated. bubbles
//   keep moving whenever the output register is empty or taken.
// ---------------------------------------------------------------------------
`default_nettype none

`include "signed_fixed_point_alu_top_macros.svh"

module signed_fixed_point_alu_top #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sfpa_in_if.sink   in_i,
  sfpa_out_if.source out_o
);
  import sfpa_pkg::*;

  localparam int QW = 32 + FRAC_BITS;

  logic          adv;
  logic [QW:0]   vld_q;
  stage_t        st_q [QW+1];
  stage_t        st_d [QW+1];
  logic          vld_m_q;
  stage_t        st_m_q;
  logic [63:0]   prod_q;
  logic          out_vld_q;
  logic [31:0]   res_q;
  logic          cmp_q;
  logic          dz_q;

  // global advance
  assign adv        = !out_vld_q || out_o.ready;
  assign in_i.ready = adv;

  // entry stage: simple ops, magnitudes, sign
  always_comb begin
    logic signed [31:0] a;
    logic signed [31:0] b;
    a = in_i.operand_a;
    b = in_i.operand_b;
    st_d[0].cmd   = cmd_e'(in_i.command);
    st_d[0].neg   = a[31] ^ b[31];
    st_d[0].mag_a = a[31] ? 32'(-a) : a;
    st_d[0].mag_b = b[31] ? 32'(-b) : b;
    st_d[0].rem   = '0;
    st_d[0].quo   = '0;
    st_d[0].simple_res = '0;
    st_d[0].cmp   = 1'b0;
    unique case (cmd_e'(in_i.command))
      CMD_ADD:     st_d[0].simple_res = a + b;
      CMD_SUB:     st_d[0].simple_res = a - b;
      CMD_LT:      st_d[0].cmp = (a < b);
      CMD_GT:      st_d[0].cmp = (a > b);
      CMD_LE:      st_d[0].cmp = (a <= b);
      CMD_GE:      st_d[0].cmp = (a >= b);
      CMD_EQ:      st_d[0].cmp = (a == b);
      CMD_NE:      st_d[0].cmp = (a != b);
      CMD_MIN:     st_d[0].simple_res = (a <= b) ? a : b;
      CMD_MAX:     st_d[0].simple_res = (a >= b) ? a : b;
      CMD_INC:     st_d[0].simple_res = a + 32'sd1;
      CMD_DEC:     st_d[0].simple_res = a - 32'sd1;
      CMD_TOINT:   st_d[0].simple_res = a >>> FRAC_BITS;
      CMD_FROMINT: st_d[0].simple_res = a << FRAC_BITS;
      default:     st_d[0].simple_res = '0;
    endcase
  end

  // divider stages, one quotient bit each
  for (genvar j = 0; j < QW; j++) begin : g_div
    always_comb begin
      logic        dbit;
      logic [32:0] sh;
      logic [33:0] diff;
      dbit = (j < 32) ? st_q[j].mag_a[(j < 32) ? 31 - j : 0] : 1'b0;
      sh   = {st_q[j].rem, dbit};
      diff = {1'b0, sh} - {2'b00, st_q[j].mag_b};
      st_d[j+1] = st_q[j];
      if (!diff[33]) begin
        st_d[j+1].rem = diff[31:0];
        st_d[j+1].quo = {st_q[j].quo[30:0], 1'b1};
      end else begin
        st_d[j+1].rem = sh[31:0];
        st_d[j+1].quo = {st_q[j].quo[30:0], 1'b0};
      end
    end
  end

  // pipe valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      vld_m_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[QW-1:0], in_i.valid};
      vld_m_q   <= vld_q[QW];
      out_vld_q <= vld_m_q;
    end
  end

  // pipe payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k <= QW; k++) begin
        st_q[k] <= st_d[k];
      end
      st_m_q <= st_q[QW];
      prod_q <= st_q[QW].mag_a * st_q[QW].mag_b;
    end
  end

  // result select and output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      logic [31:0] m;
      m = prod_q[FRAC_BITS +: 32];
      cmp_q <= st_m_q.cmp;
      dz_q  <= 1'b0;
      unique case (st_m_q.cmd)
        CMD_MUL: res_q <= st_m_q.neg ? 32'(-m) : m;
        CMD_DIV: begin
          if (st_m_q.mag_b == '0) begin
            res_q <= '0;
            dz_q  <= 1'b1;
          end else begin
            res_q <= st_m_q.neg ? 32'(-st_m_q.quo) : st_m_q.quo;
          end
        end
        default: res_q <= st_m_q.simple_res;
      endcase
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.result_value   = res_q;
  assign out_o.compare_true   = cmp_q;
  assign out_o.divide_by_zero = dz_q;

  // checks
  `SFPA_ASSERT_NOW(a_dz_zero, clk_i, rst_ni, out_o.valid && out_o.divide_by_zero,
    out_o.result_value == 32'sd0 && !out_o.compare_true, "divide by zero with nonzero result")
  `SFPA_ASSERT_NOW(a_cmp_zero, clk_i, rst_ni, out_o.valid && out_o.compare_true,
    out_o.result_value == 32'sd0, "comparison with nonzero result")
  `SFPA_ASSERT_NOW(a_stall, clk_i, rst_ni, out_o.valid && !out_o.ready,
    !in_i.ready, "input taken while output stalled")
  `SFPA_ASSERT_NOW(a_rem, clk_i, rst_ni,
    vld_q[QW] && st_q[QW].cmd == CMD_DIV && st_q[QW].mag_b != '0,
    st_q[QW].rem < st_q[QW].mag_b, "divider remainder out of range")

endmodule

`default_nettype wire
